@@ rtl/flow_size_sketch_table_unit_defines.svh @@
// ----------------------------------------------------------------------------
// flow size sketch table: assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef FLOW_SIZE_SKETCH_TABLE_UNIT_DEFINES_SVH
`define FLOW_SIZE_SKETCH_TABLE_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define FSST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FSST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fsst_pkg.sv @@
// ----------------------------------------------------------------------------
// fsst_pkg
// widths, limits, codes and shared types of the flow size sketch table
// ----------------------------------------------------------------------------
`default_nettype none

package fsst_pkg;

    // input field widths
    localparam int KIND_W     = 1;
    localparam int SLOT_IN_W  = 10;
    localparam int HOME_IN_W  = 12;
    localparam int MAX_ROWS   = 4;

    // filter counters
    localparam int              FILT_W   = 6;
    localparam logic [FILT_W-1:0] FILT_MAX = 6'd63;

    // bucket counters
    localparam int             CNT_W   = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // probe exponent range covers every sentinel value
    localparam int STEP_EXP_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 1'b1;

    // commands from the sequencer to the filter banks
    typedef struct packed {
        logic rd;
        logic upd;
        logic clr;
    } t_filt_cmd;

endpackage

`default_nettype wire

@@ rtl/fsst_ram.sv @@
// ----------------------------------------------------------------------------
// fsst_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fsst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/fsst_modred.sv @@
// ----------------------------------------------------------------------------
// fsst_modred
// reduces a hashed index modulo a table size, by a reciprocal multiplication
// when the size is not a power of two and the index can exceed it
// ----------------------------------------------------------------------------
`default_nettype none

module fsst_modred #(
    parameter int IN_W = 12,
    parameter int MOD  = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [IN_W-1:0]        i_value,
    output logic                        o_busy,
    output logic      [$clog2(MOD)-1:0] o_rem
);

    localparam int OUT_W = $clog2(MOD);
    localparam bit POW2  = (MOD & (MOD - 1)) == 0;
    localparam bit NEED  = !POW2 && ((2 ** IN_W) > MOD);

    generate
        if (NEED) begin : g_recip
            // quotient = (value * ceil(2^SH / MOD)) >> SH, exact below 2^IN_W
            localparam int              SH    = IN_W + OUT_W;
            localparam int              MW    = IN_W + 2;
            localparam int              PW    = IN_W + MW;
            localparam longint unsigned RECIP = ((64'd1 << SH) + MOD - 1) / MOD;

            logic [IN_W-1:0]       r_val;
            logic [IN_W-1:0]       r_quot;
            logic [OUT_W-1:0]      r_rem;
            logic [1:0]            r_cnt;
            logic [PW-1:0]         w_prod;
            logic [IN_W+OUT_W-1:0] w_back;

            assign w_prod = r_val * MW'(RECIP);
            assign w_back = r_quot * OUT_W'(MOD);

            // quotient registered first, then the remainder from it
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_start) begin
                    r_cnt <= 2'd2;
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
                if (i_start) begin
                    r_val <= i_value;
                end
                if (r_cnt == 2'd2) begin
                    r_quot <= IN_W'(w_prod >> SH);
                end
                if (r_cnt == 2'd1) begin
                    r_rem <= OUT_W'(r_val - w_back[IN_W-1:0]);
                end
            end

            assign o_busy = r_cnt != '0;
            assign o_rem  = r_rem;
        end else begin : g_direct
            logic [OUT_W-1:0] r_rem;

            // power of two size or index always in range: a mask or an extension
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= OUT_W'(i_value);
                end
            end

            assign o_busy = 1'b0;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/fsst_filter.sv @@
// ----------------------------------------------------------------------------
// fsst_filter
// flow filter: one counter bank per row, filter value and lowering update
// ----------------------------------------------------------------------------
`default_nettype none

module fsst_filter
    import fsst_pkg::*;
#(
    parameter int NUM_ROWS = 3,
    parameter int ROW_LEN  = 1024
) (
    input  wire logic                                     i_clk,
    input  wire t_filt_cmd                                i_cmd,
    input  wire logic [NUM_ROWS-1:0][$clog2(ROW_LEN)-1:0] i_slot,
    input  wire logic [$clog2(ROW_LEN)-1:0]               i_clr_idx,
    input  wire logic [FILT_W-1:0]                        i_upd_val,
    output logic      [FILT_W-1:0]                        o_fval
);

    localparam int RW = $clog2(ROW_LEN);

    logic [NUM_ROWS-1:0][FILT_W-1:0] w_rd;

    // one bank per row, read in parallel
    generate
        for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
            logic              we;
            logic [RW-1:0]     waddr;
            logic [FILT_W-1:0] wdata;

            // counters that are empty or above the update value take it
            assign we    = i_cmd.clr ||
                           (i_cmd.upd && ((w_rd[r] == '0) || (w_rd[r] > i_upd_val)));
            assign waddr = i_cmd.clr ? i_clr_idx : i_slot[r];
            assign wdata = i_cmd.clr ? '0 : i_upd_val;

            fsst_ram #(
                .WIDTH (FILT_W),
                .DEPTH (ROW_LEN)
            ) u_bank (
                .i_clk   (i_clk),
                .i_we    (we),
                .i_waddr (waddr),
                .i_wdata (wdata),
                .i_re    (i_cmd.rd),
                .i_raddr (i_slot[r]),
                .o_rdata (w_rd[r])
            );
        end
    endgenerate

    // maximum over the rows, zero when any row is empty
    always_comb begin
        logic [FILT_W-1:0] mx;
        logic              any_zero;
        mx       = '0;
        any_zero = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (w_rd[r] == '0) begin
                any_zero = 1'b1;
            end
            if (w_rd[r] > mx) begin
                mx = w_rd[r];
            end
        end
        o_fval = any_zero ? '0 : mx;
    end

endmodule

`default_nettype wire

@@ rtl/flow_size_sketch_table_unit.sv @@
// ----------------------------------------------------------------------------
// flow_size_sketch_table_unit
// flow size estimator: flow filter banks in front of a probed bucket table
// ----------------------------------------------------------------------------
// One item is handled at a time. An accepted item passes through index
// reduction and a read of the filter banks and the home bucket; unless it
// is a query of an unknown flow or an insert placed in its home bucket,
// the probe step table is looked up and the probed bucket read. An insert
// writes a bucket back and may lower the filter. The order follows the
// read and write ports of the bucket memory (home bucket, then probed
// bucket), with the lookup of the probe step table between them. When a
// table size is not a power of two and the hashed index can exceed it, the
// index reduction waits for a reciprocal multiplication. A finished result
// waits in an output register while the next item is already taken. After
// reset a clearing pass zeroes the filter and the buckets and fills the
// probe step table; no item is taken during it.
`default_nettype none

`include "flow_size_sketch_table_unit_defines.svh"

module flow_size_sketch_table_unit
    import fsst_pkg::*;
#(
    parameter int NUM_ROWS   = 3,
    parameter int ROW_LEN    = 1024,
    parameter int TABLE_SIZE = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [SLOT_IN_W-1:0] i_row_slot_0,
    input  wire logic [SLOT_IN_W-1:0] i_row_slot_1,
    input  wire logic [SLOT_IN_W-1:0] i_row_slot_2,
    input  wire logic [SLOT_IN_W-1:0] i_row_slot_3,
    input  wire logic [HOME_IN_W-1:0] i_home_bucket,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [CNT_W-1:0]     o_flow_cnt,
    output logic                      o_evicted
);

    localparam int TW         = $clog2(TABLE_SIZE);
    localparam int RW         = $clog2(ROW_LEN);
    localparam int STEP_DEPTH = 1 << STEP_EXP_W;
    localparam int CLR_LEN0   = (ROW_LEN > TABLE_SIZE) ? ROW_LEN : TABLE_SIZE;
    localparam int CLR_LEN    = (CLR_LEN0 > STEP_DEPTH) ? CLR_LEN0 : STEP_DEPTH;
    localparam int CLR_IW     = $clog2(CLR_LEN);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RED,
        S_HOME,
        S_STEP,
        S_BUCK,
        S_FILT,
        S_DONE
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // filter update value for a placed flow with sentinel s
    function automatic logic [FILT_W-1:0] place_val(input logic [CNT_W-1:0] s);
        return (s >= CNT_W'(FILT_MAX - 1'b1)) ? FILT_MAX : FILT_W'(s + 1'b1);
    endfunction

    // registers
    t_state              r_state, n_state;
    logic [CLR_IW-1:0]   r_clr_idx, n_clr_idx;
    logic [TW-1:0]       r_step_val, n_step_val;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [FILT_W-1:0]   r_fval, n_fval;
    logic [CNT_W-1:0]    r_s, n_s;
    logic [TW-1:0]       r_b, n_b;
    logic [FILT_W-1:0]   r_upd, n_upd;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_evict, n_evict;
    logic                r_out_valid, n_out_valid;
    logic [CNT_W-1:0]    r_out_count, n_out_count;
    logic                r_out_evict, n_out_evict;

    // datapath nets
    logic                                 in_accept;
    logic [MAX_ROWS-1:0][SLOT_IN_W-1:0]   w_slot_in;
    logic [NUM_ROWS-1:0][RW-1:0]          w_slot;
    logic [NUM_ROWS-1:0]                  w_slot_busy;
    logic [TW-1:0]                        w_home;
    logic                                 w_home_busy;
    logic                                 red_busy;
    logic [FILT_W-1:0]                    w_fval;
    t_filt_cmd                            fcmd;

    logic                 bkt_we, bkt_re;
    logic [TW-1:0]        bkt_waddr, bkt_raddr;
    logic [2*CNT_W-1:0]   bkt_wdata, bkt_rdata;
    logic [CNT_W-1:0]     bkt_sent, bkt_flows;
    logic [CNT_W-1:0]     home_s, bkt_nf;

    logic                    stp_we, stp_re;
    logic [STEP_EXP_W-1:0]   stp_waddr, stp_raddr;
    logic [TW-1:0]           stp_wdata, stp_rdata;

    logic          clr_last, clr_in_tbl, clr_in_row, clr_in_stp;
    logic [TW:0]   step_dbl, probe_sum;
    logic [TW-1:0] step_next, probe_b;
    logic          out_load;

    assign in_accept = i_in_valid && o_in_ready;
    assign w_slot_in = {i_row_slot_3, i_row_slot_2, i_row_slot_1, i_row_slot_0};

    // index reduction, started at acceptance
    fsst_modred #(
        .IN_W (HOME_IN_W),
        .MOD  (TABLE_SIZE)
    ) u_home_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_value (i_home_bucket),
        .o_busy  (w_home_busy),
        .o_rem   (w_home)
    );

    generate
        for (genvar r = 0; r < NUM_ROWS; r++) begin : g_slot
            fsst_modred #(
                .IN_W (SLOT_IN_W),
                .MOD  (ROW_LEN)
            ) u_slot_red (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (in_accept),
                .i_value (w_slot_in[r]),
                .o_busy  (w_slot_busy[r]),
                .o_rem   (w_slot[r])
            );
        end
    endgenerate

    assign red_busy = w_home_busy || (|w_slot_busy);

    // filter banks
    fsst_filter #(
        .NUM_ROWS (NUM_ROWS),
        .ROW_LEN  (ROW_LEN)
    ) u_filter (
        .i_clk     (i_clk),
        .i_cmd     (fcmd),
        .i_slot    (w_slot),
        .i_clr_idx (r_clr_idx[RW-1:0]),
        .i_upd_val (r_upd),
        .o_fval    (w_fval)
    );

    // bucket table: sentinel in the upper half, flow count in the lower half
    fsst_ram #(
        .WIDTH (2 * CNT_W),
        .DEPTH (TABLE_SIZE)
    ) u_buckets (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_re    (bkt_re),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    // probe step table, step(e) = (2^e - 1) mod TABLE_SIZE
    fsst_ram #(
        .WIDTH (TW),
        .DEPTH (STEP_DEPTH)
    ) u_steps (
        .i_clk   (i_clk),
        .i_we    (stp_we),
        .i_waddr (stp_waddr),
        .i_wdata (stp_wdata),
        .i_re    (stp_re),
        .i_raddr (stp_raddr),
        .o_rdata (stp_rdata)
    );

    assign bkt_sent  = bkt_rdata[2*CNT_W-1:CNT_W];
    assign bkt_flows = bkt_rdata[CNT_W-1:0];
    assign home_s    = sat_inc(bkt_sent);
    assign bkt_nf    = sat_inc(bkt_flows);

    // clearing pass bounds
    assign clr_last   = r_clr_idx == CLR_IW'(CLR_LEN - 1);
    assign clr_in_tbl = {1'b0, r_clr_idx} < (CLR_IW + 1)'(TABLE_SIZE);
    assign clr_in_row = {1'b0, r_clr_idx} < (CLR_IW + 1)'(ROW_LEN);
    assign clr_in_stp = {1'b0, r_clr_idx} < (CLR_IW + 1)'(STEP_DEPTH);

    // step recurrence: next = (2 * step + 1) mod TABLE_SIZE
    assign step_dbl  = {r_step_val, 1'b1};
    assign step_next = (step_dbl >= (TW + 1)'(TABLE_SIZE)) ?
                       TW'(step_dbl - (TW + 1)'(TABLE_SIZE)) : step_dbl[TW-1:0];

    // probed bucket = home + step mod TABLE_SIZE
    assign probe_sum = {1'b0, w_home} + {1'b0, stp_rdata};
    assign probe_b   = (probe_sum >= (TW + 1)'(TABLE_SIZE)) ?
                       TW'(probe_sum - (TW + 1)'(TABLE_SIZE)) : probe_sum[TW-1:0];

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // sequencer: read, modify and write back the stores
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_step_val  = r_step_val;
        n_kind      = r_kind;
        n_fval      = r_fval;
        n_s         = r_s;
        n_b         = r_b;
        n_upd       = r_upd;
        n_count     = r_count;
        n_evict     = r_evict;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_count = r_out_count;
        n_out_evict = r_out_evict;

        fcmd      = '0;
        bkt_we    = 1'b0;
        bkt_waddr = w_home;
        bkt_wdata = '0;
        bkt_re    = 1'b0;
        bkt_raddr = w_home;
        stp_we    = 1'b0;
        stp_waddr = r_clr_idx[STEP_EXP_W-1:0];
        stp_wdata = r_step_val;
        stp_re    = 1'b0;
        stp_raddr = STEP_EXP_W'(r_fval) - 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                fcmd.clr  = clr_in_row;
                bkt_we    = clr_in_tbl;
                bkt_waddr = r_clr_idx[TW-1:0];
                stp_we    = clr_in_stp;
                n_step_val = step_next;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_kind  = i_kind;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (!red_busy) begin
                    fcmd.rd   = 1'b1;
                    bkt_re    = 1'b1;
                    bkt_raddr = w_home;
                    n_state   = S_HOME;
                end
            end
            S_HOME: begin
                n_fval  = w_fval;
                n_count = '0;
                n_evict = 1'b0;
                n_upd   = '0;
                if (r_kind == KIND_QUERY) begin
                    if (w_fval > FILT_W'(1)) begin
                        stp_re    = 1'b1;
                        stp_raddr = STEP_EXP_W'(w_fval) - STEP_EXP_W'(2);
                        n_state   = S_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (w_fval <= FILT_W'(1)) begin
                    // new flow: count it in the home sentinel
                    bkt_we    = 1'b1;
                    bkt_waddr = w_home;
                    n_s       = home_s;
                    if (home_s == CNT_W'(1)) begin
                        bkt_wdata = {home_s, bkt_nf};
                        n_upd     = place_val(home_s);
                        n_state   = S_FILT;
                    end else begin
                        bkt_wdata = {home_s, bkt_flows};
                        stp_re    = 1'b1;
                        stp_raddr = home_s - 1'b1;
                        n_state   = S_STEP;
                    end
                end else begin
                    stp_re    = 1'b1;
                    stp_raddr = STEP_EXP_W'(w_fval) - STEP_EXP_W'(2);
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                bkt_re    = 1'b1;
                bkt_raddr = probe_b;
                n_b       = probe_b;
                n_state   = S_BUCK;
            end
            S_BUCK: begin
                bkt_waddr = r_b;
                if (r_kind == KIND_QUERY) begin
                    n_count = bkt_flows;
                    n_state = S_DONE;
                end else if (r_fval <= FILT_W'(1)) begin
                    // new flow placed in the probed bucket only when it is empty
                    if (bkt_flows != '0) begin
                        n_state = S_DONE;
                    end else begin
                        bkt_we    = 1'b1;
                        bkt_wdata = {sat_inc(bkt_sent), bkt_nf};
                        n_upd     = place_val(r_s);
                        n_state   = S_FILT;
                    end
                end else begin
                    // existing flow: count it, evict when the sentinel leads
                    bkt_we = 1'b1;
                    if (bkt_nf < bkt_sent) begin
                        bkt_wdata = {{CNT_W{1'b0}}, bkt_nf};
                        n_evict   = 1'b1;
                        n_upd     = FILT_W'(1);
                        n_state   = S_FILT;
                    end else begin
                        bkt_wdata = {bkt_sent, bkt_nf};
                        n_state   = S_DONE;
                    end
                end
            end
            S_FILT: begin
                fcmd.upd = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_out_evict = r_evict;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_step_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_step_val  <= n_step_val;
            r_out_valid <= n_out_valid;
        end
        r_kind      <= n_kind;
        r_fval      <= n_fval;
        r_s         <= n_s;
        r_b         <= n_b;
        r_upd       <= n_upd;
        r_count     <= n_count;
        r_evict     <= n_evict;
        r_out_count <= n_out_count;
        r_out_evict <= n_out_evict;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_flow_cnt  = r_out_count;
    assign o_evicted   = r_out_evict;

    // bucket port is never read and written in the same cycle
    `FSST_ASSERT_SAME(a_bkt_rw_excl, i_clk, i_rst_n, bkt_re, !bkt_we, "bucket read and write overlap")

    // an evicting insert never reports a count
    `FSST_ASSERT_SAME(a_evict_no_count, i_clk, i_rst_n, o_out_valid && o_evicted, o_flow_cnt == '0, "evicted result with count")

    // the filter is lowered only with a nonzero value
    `FSST_ASSERT_SAME(a_filt_upd_val, i_clk, i_rst_n, r_state == S_FILT, r_upd != '0, "filter update with zero value")

    // every probe step read back lies inside the table
    `FSST_ASSERT_SAME(a_step_range, i_clk, i_rst_n, r_state == S_STEP, {1'b0, stp_rdata} < (TW + 1)'(TABLE_SIZE), "probe step out of range")

    // a finished item shows up at the output
    `FSST_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, o_out_valid, "result not presented")

endmodule

`default_nettype wire
